[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; clock clk, reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define TCCW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define TCCW_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/core/tccw_pkg.sv]
// ----------------------------------------------------------------------------
// tccw_pkg
// Types and constants shared by the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COPY_N     = COLUMNS * (ROWS - 1);
	localparam int CELL_AW    = $clog2(CELL_COUNT);
	localparam int CNT_W      = $clog2(CELL_COUNT + 1);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);

	localparam logic [7:0]  CH_BS     = 8'h08;
	localparam logic [7:0]  CH_LF     = 8'h0A;
	localparam logic [7:0]  CH_CR     = 8'h0D;
	localparam logic [7:0]  CH_SPACE  = 8'h20;
	localparam logic [7:0]  CH_TILDE  = 8'h7E;
	localparam logic [15:0] CELL_RESET = 16'h0F20;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} tccw_cmd_t;

	typedef enum logic [1:0] {
		CFG_TEXT  = 2'd0,
		CFG_BACK  = 2'd1,
		CFG_BLINK = 2'd2
	} tccw_cfg_idx_t;

	typedef enum logic [1:0] {
		BK_INIT,
		BK_IDLE,
		BK_READ,
		BK_WALK
	} tccw_bk_state_t;

	typedef struct packed {
		tccw_cmd_t   command;
		logic [7:0]  char_code;
		logic [10:0] cell_address;
	} tccw_item_t;

	typedef struct packed {
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
		logic [15:0] read_data;
		logic        scrolled;
	} tccw_result_t;

	// Classified operation handed from front to back.
	typedef struct packed {
		logic               wr_en;
		logic [CELL_AW-1:0] wr_addr;
		logic [15:0]        wr_data;
		logic               read;
		logic               rd_valid;
		logic [CELL_AW-1:0] rd_addr;
		logic               clear;
		logic               scroll;
		logic [15:0]        fill;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
	} tccw_op_t;

	typedef struct packed {
		logic init_busy;
	} tccw_status_t;

endpackage

[rtl/core/tccw_front.sv]
// ----------------------------------------------------------------------------
// tccw_front
// Holds the configuration and cursor, classifies each command into an op.
// ----------------------------------------------------------------------------
module tccw_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [1:0]            cfg_index,
	input  logic [3:0]            cfg_data,
	input  logic                  accept,
	input  tccw_pkg::tccw_item_t  item,
	output tccw_pkg::tccw_op_t    op
);
	import tccw_pkg::*;

	logic [3:0]         text_q;
	logic [2:0]         back_q;
	logic               blink_q;
	logic [COL_W-1:0]   col_q, col_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [CELL_AW-1:0] pos;
	logic               last_col, last_row;
	logic [15:0]        fill;
	logic [7:0]         c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_q  <= 4'hF;
			back_q  <= 3'd0;
			blink_q <= 1'b0;
		end else if (cfg_wen) begin
			unique case (tccw_cfg_idx_t'(cfg_index))
				CFG_TEXT:  text_q  <= cfg_data;
				CFG_BACK:  back_q  <= cfg_data[2:0];
				CFG_BLINK: blink_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	assign c        = item.char_code;
	assign fill     = {blink_q, back_q, text_q, CH_SPACE};
	assign pos      = CELL_AW'(row_q * COLUMNS) + CELL_AW'(col_q);
	assign last_col = (col_q == COL_W'(COLUMNS - 1));
	assign last_row = (row_q == ROW_W'(ROWS - 1));

	always_comb begin
		col_d = col_q;
		row_d = row_q;
		op    = '0;
		op.fill = fill;
		unique case (item.command)
			CMD_WRITE: begin
				priority if (c == CH_CR) begin
					col_d = '0;
				end else if (c == CH_LF) begin
					col_d = '0;
					if (last_row) op.scroll = 1'b1;
					else row_d = row_q + 1'b1;
				end else if (c == CH_BS) begin
					op.wr_en   = 1'b1;
					op.wr_addr = (pos == '0) ? '0 : pos - 1'b1;
					op.wr_data = fill;
					if (col_q != '0) begin
						col_d = col_q - 1'b1;
					end else if (row_q != '0) begin
						row_d = row_q - 1'b1;
						col_d = COL_W'(COLUMNS - 1);
					end
				end else if (c >= CH_SPACE && c <= CH_TILDE) begin
					op.wr_en   = 1'b1;
					op.wr_addr = pos;
					op.wr_data = {1'b0, back_q, text_q, c};
					if (last_col) begin
						col_d = '0;
						if (last_row) op.scroll = 1'b1;
						else row_d = row_q + 1'b1;
					end else begin
						col_d = col_q + 1'b1;
					end
				end
			end
			CMD_READ: begin
				op.read     = 1'b1;
				op.rd_valid = (32'(item.cell_address) < CELL_COUNT);
				op.rd_addr  = CELL_AW'(item.cell_address);
			end
			CMD_CLEAR: begin
				op.clear = 1'b1;
				col_d    = '0;
				row_d    = '0;
			end
			CMD_NONE: ;
			default: ;
		endcase
		op.col = col_d;
		op.row = row_d;
	end

endmodule

[rtl/core/tccw_op_queue.sv]
// ----------------------------------------------------------------------------
// tccw_op_queue
// Two-entry queue of classified ops between front and back.
// ----------------------------------------------------------------------------
module tccw_op_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tccw_pkg::tccw_op_t push_op,
	input  logic               pop,
	output tccw_pkg::tccw_op_t head,
	output logic               empty,
	output logic               full
);
	import tccw_pkg::*;

	tccw_op_t   slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign empty   = (count_q == 2'd0);
	assign full    = (count_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

[rtl/core/tccw_back.sv]
// ----------------------------------------------------------------------------
// tccw_back
// Owns the screen memory; executes ops, walks for scroll/clear/reset fill.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tccw_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tccw_pkg::tccw_op_t     op,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  logic                   res_pop,
	output tccw_pkg::tccw_result_t result,
	output logic                   res_valid,
	output tccw_pkg::tccw_status_t status
);
	import tccw_pkg::*;

	logic [15:0]        mem [CELL_COUNT];
	logic [15:0]        rd_data_q;

	tccw_bk_state_t     st_q, st_d;
	logic [CNT_W-1:0]   walk_q;
	logic               scroll_mode_q;
	logic [15:0]        fill_q;
	logic               wv_s1, wcopy_s1;
	logic [CELL_AW-1:0] wa_s1;

	logic [COL_W-1:0]   pcol_q;
	logic [ROW_W-1:0]   prow_q;
	logic               pscr_q, rd_ok_q;

	tccw_result_t       res_q, res_d;
	logic               res_valid_q, res_load, res_take;

	logic               take, walk_start, walk_issue, walk_more, copy_now;
	logic               mem_we, mem_re;
	logic [CELL_AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]        mem_wdata;

	assign res_take  = res_pop && res_valid_q;
	assign take      = (st_q == BK_IDLE) && !q_empty && (!res_valid_q || res_take);
	assign walk_more = (walk_q < CNT_W'(CELL_COUNT));
	assign copy_now  = scroll_mode_q && (walk_q < CNT_W'(COPY_N));

	assign result           = res_q;
	assign res_valid        = res_valid_q;
	assign status.init_busy = (st_q == BK_INIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_INIT;
		else         st_q <= st_d;
	end

	always_comb begin
		st_d       = st_q;
		q_pop      = 1'b0;
		walk_start = 1'b0;
		walk_issue = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		res_load   = 1'b0;
		res_d      = '0;
		// drain the delayed walk write
		mem_we     = wv_s1;
		mem_waddr  = wa_s1;
		mem_wdata  = wcopy_s1 ? rd_data_q : fill_q;
		unique case (st_q)
			BK_INIT: begin
				if (walk_more) begin
					walk_issue = 1'b1;
				end else if (!wv_s1) begin
					st_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (take) begin
					q_pop = 1'b1;
					if (op.wr_en) begin
						mem_we    = 1'b1;
						mem_waddr = op.wr_addr;
						mem_wdata = op.wr_data;
					end
					if (op.clear || op.scroll) begin
						walk_start = 1'b1;
						st_d       = BK_WALK;
					end else if (op.read) begin
						mem_re    = op.rd_valid;
						mem_raddr = op.rd_addr;
						st_d      = BK_READ;
					end else begin
						res_load            = 1'b1;
						res_d.cursor_column = 7'(op.col);
						res_d.cursor_row    = 5'(op.row);
					end
				end
			end
			BK_READ: begin
				res_load            = 1'b1;
				res_d.cursor_column = 7'(pcol_q);
				res_d.cursor_row    = 5'(prow_q);
				res_d.read_data     = rd_ok_q ? rd_data_q : 16'h0000;
				st_d                = BK_IDLE;
			end
			BK_WALK: begin
				if (walk_more) begin
					walk_issue = 1'b1;
					if (copy_now) begin
						mem_re    = 1'b1;
						mem_raddr = CELL_AW'(walk_q) + CELL_AW'(COLUMNS);
					end
				end else if (!wv_s1) begin
					res_load            = 1'b1;
					res_d.cursor_column = 7'(pcol_q);
					res_d.cursor_row    = 5'(prow_q);
					res_d.scrolled      = pscr_q;
					st_d                = BK_IDLE;
				end
			end
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q        <= '0;
			scroll_mode_q <= 1'b0;
			fill_q        <= CELL_RESET;
			wv_s1         <= 1'b0;
		end else begin
			wv_s1 <= walk_issue;
			if (walk_start) begin
				walk_q        <= '0;
				scroll_mode_q <= op.scroll && !op.clear;
				fill_q        <= op.fill;
			end else if (walk_issue) begin
				walk_q <= walk_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wa_s1    <= CELL_AW'(walk_q);
		wcopy_s1 <= copy_now;
		if (take) begin
			pcol_q  <= op.col;
			prow_q  <= op.row;
			pscr_q  <= op.scroll;
			rd_ok_q <= op.rd_valid;
		end
		if (res_load) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else         res_valid_q <= res_load || (res_valid_q && !res_take);
	end

	`TCCW_NEVER(a_idle_walk_write, (st_q == BK_IDLE) && wv_s1, "walk write pending in idle")
	`TCCW_NEVER(a_result_overrun, res_load && res_valid_q && !res_take, "result overwritten")
	`TCCW_ASSERT(a_walk_bound, walk_q <= CNT_W'(CELL_COUNT), "walk counter out of range")
	`TCCW_ASSERT(a_read_follows_take, (st_q == BK_READ) |-> $past(q_pop), "read state w/o op")

endmodule

[rtl/core/text_console_char_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// Character-cell console writer: cursor, screen memory, scroll and clear.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  --------  -------------------  -----------------------------------------
//  input     push / full          item   (command, char_code, cell_address)
//  result    pop / empty          result (cursor_column, cursor_row,
//                                         read_data, scrolled)
//  config    cfg_wen              cfg_index, cfg_data (no wait, no read-back)
//
//  Character writes, carriage return and ignored bytes: one item per cycle
//  while each result is popped as it appears. Reads pass through a read state,
//  limited by the registered read port of the screen memory. Scroll and clear:
//  the back walks memory, one cell per cycle through the single memory write
//  port, then drains the delayed write. After reset a fill pass blanks the
//  memory; full stays high until it ends. A two-entry op queue lets the front
//  take items while the back walks memory or a result waits to be popped.
// ----------------------------------------------------------------------------
module text_console_char_writer_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  tccw_pkg::tccw_item_t   item,
	output logic                   empty,
	input  logic                   pop,
	output tccw_pkg::tccw_result_t result,
	input  logic                   cfg_wen,
	input  logic [1:0]             cfg_index,
	input  logic [3:0]             cfg_data
);
	import tccw_pkg::*;

	tccw_op_t     front_op, head_op;
	tccw_status_t bk_status;
	logic         q_full, q_empty, q_pop;
	logic         accept, res_valid;

	// Hold off input during the post-reset fill pass and while the queue is full.
	assign full   = q_full || bk_status.init_busy;
	assign accept = push && !full;
	assign empty  = !res_valid;

	// Front: classify each transfer and advance the cursor.
	tccw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.op        (front_op)
	);

	// Decouple front and back.
	tccw_op_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.push_op (front_op),
		.pop     (q_pop),
		.head    (head_op),
		.empty   (q_empty),
		.full    (q_full)
	);

	// Back: execute ops against the screen memory and drive results.
	tccw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (head_op),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.res_pop   (pop),
		.result    (result),
		.res_valid (res_valid),
		.status    (bk_status)
	);

endmodule

[test/tccw_result_checker.sv]
// ----------------------------------------------------------------------------
// tccw_result_checker
// Watches the item, result and register ports of the console writer. Keeps
// its own screen, cursor and colors, predicts one report per item transfer
// and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tccw_result_checker
	import tccw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic         full,
	input  tccw_item_t   item,
	input  logic         empty,
	input  logic         pop,
	input  tccw_result_t result,
	input  logic         cfg_wen,
	input  logic [1:0]   cfg_index,
	input  logic [3:0]   cfg_data,
	output int           failures,
	output int           outstanding,
	output int           checked,
	output int           scrolls
);

	logic [15:0]  screen_mem [CELL_COUNT];
	int           cur_col;
	int           cur_row;
	logic [3:0]   fg_color;
	logic [2:0]   bg_color;
	logic         blink_on;
	tccw_result_t awaited_reports [$];
	int           fail_cnt;
	int           check_cnt;
	int           scroll_cnt;

	function automatic tccw_result_t predict_report(input tccw_item_t it);
		tccw_result_t rep;
		logic [15:0]  fill;
		int           pos;
		int           k;
		bit           rolled;
		rep    = '0;
		rolled = 1'b0;
		fill   = {blink_on, bg_color, fg_color, CH_SPACE};
		case (it.command)
			CMD_WRITE: begin
				if (it.char_code == CH_CR) begin
					cur_col = 0;
				end else if (it.char_code == CH_LF) begin
					cur_col = 0;
					cur_row++;
				end else if (it.char_code == CH_BS) begin
					// the home cell blanks itself, anything else blanks its predecessor
					pos = cur_row * COLUMNS + cur_col;
					if (pos > 0)
						pos--;
					if (cur_col > 0) begin
						cur_col--;
					end else if (cur_row > 0) begin
						cur_row--;
						cur_col = COLUMNS - 1;
					end
					screen_mem[pos] = fill;
				end else if (it.char_code >= CH_SPACE && it.char_code <= CH_TILDE) begin
					screen_mem[cur_row * COLUMNS + cur_col] = {1'b0, bg_color, fg_color,
						it.char_code};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						cur_row++;
					end
				end
				if (cur_row >= ROWS) begin
					for (k = 0; k < COPY_N; k++)
						screen_mem[k] = screen_mem[k + COLUMNS];
					for (k = COPY_N; k < CELL_COUNT; k++)
						screen_mem[k] = fill;
					cur_row = ROWS - 1;
					rolled  = 1'b1;
				end
			end
			CMD_READ: begin
				if (it.cell_address < CELL_COUNT)
					rep.read_data = screen_mem[it.cell_address];
			end
			CMD_CLEAR: begin
				for (k = 0; k < CELL_COUNT; k++)
					screen_mem[k] = fill;
				cur_col = 0;
				cur_row = 0;
			end
			default: begin
			end
		endcase
		rep.cursor_column = 7'(cur_col);
		rep.cursor_row    = 5'(cur_row);
		rep.scrolled      = rolled;
		return rep;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		tccw_result_t want;
		int           k;
		if (!arst_n) begin
			for (k = 0; k < CELL_COUNT; k++)
				screen_mem[k] = CELL_RESET;
			fg_color   = CELL_RESET[11:8];
			bg_color   = CELL_RESET[14:12];
			blink_on   = CELL_RESET[15];
			cur_col    = 0;
			cur_row    = 0;
			fail_cnt   = 0;
			check_cnt  = 0;
			scroll_cnt = 0;
			awaited_reports.delete();
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					CFG_TEXT:  fg_color = cfg_data;
					CFG_BACK:  bg_color = cfg_data[2:0];
					CFG_BLINK: blink_on = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (push && !full) begin
				want = predict_report(item);
				if (want.scrolled)
					scroll_cnt++;
				awaited_reports.push_back(want);
			end
			if (pop && !empty) begin
				if (awaited_reports.size() == 0) begin
					$error("result transfer with no report pending");
					fail_cnt++;
				end else begin
					want = awaited_reports.pop_front();
					check_field("cursor_column", 32'(want.cursor_column),
						32'(result.cursor_column));
					check_field("cursor_row", 32'(want.cursor_row), 32'(result.cursor_row));
					check_field("read_data", 32'(want.read_data), 32'(result.read_data));
					check_field("scrolled", 32'(want.scrolled), 32'(result.scrolled));
					check_cnt++;
				end
			end
		end
		failures    <= fail_cnt;
		outstanding <= awaited_reports.size();
		checked     <= check_cnt;
		scrolls     <= scroll_cnt;
	end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives the console writer with a short list of edge cases and then with
// random text lines, reads, backspaces, stray bytes and clears under several
// color settings, with random gaps on both queue ports. The checker beside
// the block predicts every report; this module only drives and judges.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
	import tccw_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;     // index past the register list
	localparam int ADDR_LAST     = 2047;         // largest 11-bit cell address
	localparam int ITEM_BUDGET   = 1950;
	localparam int DIRECTED_N    = 22;
	localparam int PHASES        = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int GAP_LONG_MAX  = 40;
	// scroll or clear walks the whole memory, plus margin
	localparam int SETTLE_CYCLES = CELL_COUNT + 2 + 48;
	// every item a full walk, both sides at their longest gap, with slack for
	// sequence overrun, the init fill, phase pauses and the long hold-offs
	localparam longint LIMIT_CYCLES = 3 * (longint'(ITEM_BUDGET + ITEM_BUDGET / 2) *
		(CELL_COUNT + 2 + 2 * GAP_LONG_MAX) + (PHASES + 2) * SETTLE_CYCLES +
		2 * HOLD_CYCLES + CELL_COUNT + 1);

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         push      = 1'b0;
	logic         full;
	tccw_item_t   item      = '0;
	logic         empty;
	logic         pop       = 1'b0;
	tccw_result_t result;
	logic         cfg_wen   = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [3:0]   cfg_data  = '0;

	int     failures;
	int     outstanding;
	int     checked;
	int     scrolls;
	int     items_sent  = 0;
	int     useful_sent = 0;
	int     long_holds  = 0;
	bit     send_calm   = 1'b0;
	longint cycle_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	text_console_char_writer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tccw_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.outstanding (outstanding),
		.checked     (checked),
		.scrolls     (scrolls)
	);

	// Gap after a transfer: none in calm stretches, otherwise mostly short with
	// the occasional long one.
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, GAP_LONG_MAX);
	endfunction

	// Random cell address over the full 11-bit range.
	function automatic logic [10:0] any_addr();
		return 11'($urandom_range(0, ADDR_LAST));
	endfunction

	// Random byte over the full code range.
	function automatic logic [7:0] any_code();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic tccw_item_t make_item(input tccw_cmd_t cmd, input logic [7:0] code,
			input logic [10:0] addr);
		tccw_item_t it;
		it.command      = cmd;
		it.char_code    = code;
		it.cell_address = addr;
		return it;
	endfunction

	// Offer one item, hold it until the transfer, then maybe idle. Push stays
	// high when no gap follows, so back-to-back items never toggle it.
	task automatic send_item(input tccw_item_t it);
		int gap;
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
		// ignored bytes and the spare command do not count toward the budget
		case (it.command)
			CMD_READ, CMD_CLEAR: useful_sent++;
			CMD_WRITE: begin
				if (it.char_code == CH_CR || it.char_code == CH_LF || it.char_code == CH_BS ||
						(it.char_code >= CH_SPACE && it.char_code <= CH_TILDE))
					useful_sent++;
			end
			default: begin
			end
		endcase
		if ($urandom_range(0, 63) == 0)
			send_calm = !send_calm;
		gap = pick_gap(send_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop push, wait for every report to come back, then let a full memory
	// walk finish before anything else touches the block.
	task automatic wait_quiet();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: pop at random, with two long hold-offs mid-run so the op
	// queue backs up and full rises while the sender keeps offering.
	initial begin : result_sink
		int  gap;
		int  popped;
		bit  calm;
		popped = 0;
		calm   = 1'b0;
		wait (arst_n);
		forever begin
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			popped++;
			if (popped == 150 || popped == ITEM_BUDGET * 3 / 5) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_holds++;
			end else begin
				if ($urandom_range(0, 63) == 0)
					calm = !calm;
				gap = pick_gap(calm);
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Watchdog: end the run as a mismatch once the cycle limit is reached.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("text_console_char_writer_unit: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		int         p;
		int         k;
		int         n;
		int         len;
		int         pick;
		int         tail;
		int         target;
		int         settings;
		logic [7:0] code;
		logic [1:0] reg_idx [4];
		logic [3:0] reg_val [4];

		settings = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Edge cases under the reset colors. The first transfer waits out the
		// fill pass that follows reset.
		send_item(make_item(CMD_READ, 8'h00, 11'd0));
		send_item(make_item(CMD_WRITE, 8'h41, any_addr()));
		send_item(make_item(CMD_WRITE, CH_TILDE, any_addr()));
		send_item(make_item(CMD_WRITE, CH_SPACE, any_addr()));
		send_item(make_item(CMD_WRITE, 8'h7F, any_addr()));
		send_item(make_item(CMD_WRITE, 8'hFF, any_addr()));
		send_item(make_item(CMD_WRITE, 8'h00, any_addr()));
		send_item(make_item(CMD_WRITE, 8'h1F, any_addr()));
		send_item(make_item(CMD_READ, 8'hFF, 11'd1));
		send_item(make_item(CMD_READ, 8'h00, 11'd2));
		send_item(make_item(CMD_WRITE, CH_CR, 11'd0));
		// backspace at home blanks the home cell and leaves the cursor put
		send_item(make_item(CMD_WRITE, CH_BS, 11'd0));
		send_item(make_item(CMD_READ, 8'h00, 11'd0));
		send_item(make_item(CMD_WRITE, CH_LF, 11'(ADDR_LAST)));
		// backspace at column 0 steps back to the end of the row above
		send_item(make_item(CMD_WRITE, CH_BS, 11'd0));
		send_item(make_item(CMD_READ, 8'h00, 11'(COLUMNS - 1)));
		send_item(make_item(CMD_READ, 8'h00, 11'(CELL_COUNT - 1)));
		send_item(make_item(CMD_READ, 8'h00, 11'(CELL_COUNT)));
		send_item(make_item(CMD_READ, 8'hAA, 11'(ADDR_LAST)));
		send_item(make_item(CMD_NONE, 8'hFF, 11'(ADDR_LAST)));
		send_item(make_item(CMD_CLEAR, 8'h55, any_addr()));
		send_item(make_item(CMD_READ, 8'h00, 11'd1));
		wait_quiet();

		reg_idx[0] = CFG_SPARE;
		reg_idx[1] = CFG_TEXT;
		reg_idx[2] = CFG_BACK;
		reg_idx[3] = CFG_BLINK;

		for (p = 0; p < PHASES; p++) begin
			// Colors per phase: both extremes first, then masked upper bits,
			// then random settings. The spare index must change nothing.
			reg_val[0] = 4'($urandom);
			case (p)
				0: begin
					reg_val[1] = 4'h0;
					reg_val[2] = 4'h0;
					reg_val[3] = 4'h0;
				end
				1: begin
					reg_val[1] = 4'hF;
					reg_val[2] = 4'h7;
					reg_val[3] = 4'h1;
				end
				2: begin
					reg_val[1] = 4'h0;
					reg_val[2] = 4'hF;
					reg_val[3] = 4'hE;
				end
				3: begin
					reg_val[1] = 4'hF;
					reg_val[2] = 4'h8;
					reg_val[3] = 4'h1;
				end
				default: begin
					reg_val[1] = 4'($urandom);
					reg_val[2] = 4'($urandom);
					reg_val[3] = 4'($urandom);
				end
			endcase
			cfg_wen <= 1'b1;
			for (k = 0; k < 4; k++) begin
				cfg_index <= reg_idx[k];
				cfg_data  <= reg_val[k];
				@(posedge clk);
			end
			cfg_wen <= 1'b0;
			settings++;

			target = useful_sent + (ITEM_BUDGET - DIRECTED_N) / PHASES;
			while (useful_sent < target) begin
				pick = $urandom_range(0, 199);
				if (pick < 96) begin
					// text line, now and then long enough to wrap past the last column
					if ($urandom_range(0, 9) == 0)
						len = $urandom_range(COLUMNS - 5, 2 * COLUMNS + 10);
					else
						len = $urandom_range(0, 40);
					for (k = 0; k < len; k++) begin
						if ($urandom_range(0, 19) == 0)
							code = CH_BS;
						else
							code = 8'($urandom_range(CH_SPACE, CH_TILDE));
						send_item(make_item(CMD_WRITE, code, any_addr()));
					end
					tail = $urandom_range(0, 99);
					if (tail < 50) begin
						send_item(make_item(CMD_WRITE, CH_CR, any_addr()));
						send_item(make_item(CMD_WRITE, CH_LF, any_addr()));
					end else if (tail < 85) begin
						send_item(make_item(CMD_WRITE, CH_LF, any_addr()));
					end
				end else if (pick < 126) begin
					// reads, a fifth of them beyond the screen
					n = $urandom_range(1, 6);
					for (k = 0; k < n; k++) begin
						if ($urandom_range(0, 4) == 0)
							send_item(make_item(CMD_READ, any_code(),
								11'($urandom_range(CELL_COUNT, ADDR_LAST))));
						else
							send_item(make_item(CMD_READ, any_code(),
								11'($urandom_range(0, CELL_COUNT - 1))));
					end
				end else if (pick < 144) begin
					n = $urandom_range(1, 5);
					for (k = 0; k < n; k++)
						send_item(make_item(CMD_WRITE, CH_BS, any_addr()));
				end else if (pick < 164) begin
					// stray bytes over the whole code range
					n = $urandom_range(1, 4);
					for (k = 0; k < n; k++)
						send_item(make_item(CMD_WRITE, any_code(), any_addr()));
				end else if (pick < 176) begin
					n = $urandom_range(1, 4);
					for (k = 0; k < n; k++)
						send_item(make_item(CMD_WRITE, CH_LF, any_addr()));
				end else if (pick < 186) begin
					send_item(make_item(CMD_WRITE, CH_CR, any_addr()));
				end else if (pick < 199) begin
					send_item(make_item(CMD_NONE, any_code(), any_addr()));
				end else begin
					// rare, so the screen has time to fill and scroll between clears
					send_item(make_item(CMD_CLEAR, any_code(), any_addr()));
				end
			end
			// sender pause: every report comes back before the colors change
			wait_quiet();
		end

		$display("Covered %0d items (%0d with effect) over %0d color settings, %0d reports checked.",
			items_sent, useful_sent, settings, checked);
		$display("Screen scrolled %0d times; result side held off %0d times for %0d cycles.",
			scrolls, long_holds, HOLD_CYCLES);
		if (failures == 0 && outstanding == 0)
			$display("text_console_char_writer_unit: match");
		else
			$display("text_console_char_writer_unit: mismatch");
		$finish;
	end

endmodule
